>>> rtl/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types, constants and the cosine table function for the DFT bin unit.
// ----------------------------------------------------------------------------
package cdb_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [7:0] DIVISOR_RESET = 8'd10;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // One queued item, already classified by the front end.
  typedef struct packed {
    logic        is_load;
    logic        first;
    logic [15:0] smp;
    logic [15:0] freq;
  } cdb_item_t;

  function automatic logic [63:0] angle_q30(input logic [63:0] a);
    logic [127:0] p;
    p = 128'(a) * 128'(TWO_PI_Q30) + (128'd1 << 31);
    return p[95:32];
  endfunction

  function automatic logic [63:0] cos_q30(input logic [63:0] th);
    logic [63:0] x2;
    logic [63:0] h;
    x2 = (th * th + (64'd1 << 29)) >> 30;
    h = Q30_ONE;
    h = Q30_ONE - ((x2 * h) >> 30) / 90;
    h = Q30_ONE - ((x2 * h) >> 30) / 56;
    h = Q30_ONE - ((x2 * h) >> 30) / 30;
    h = Q30_ONE - ((x2 * h) >> 30) / 12;
    h = Q30_ONE - ((x2 * h) >> 30) / 2;
    return h;
  endfunction

  function automatic logic [63:0] sin_q30(input logic [63:0] th);
    logic [63:0] x2;
    logic [63:0] h;
    x2 = (th * th + (64'd1 << 29)) >> 30;
    h = Q30_ONE;
    h = Q30_ONE - ((x2 * h) >> 30) / 110;
    h = Q30_ONE - ((x2 * h) >> 30) / 72;
    h = Q30_ONE - ((x2 * h) >> 30) / 42;
    h = Q30_ONE - ((x2 * h) >> 30) / 20;
    h = Q30_ONE - ((x2 * h) >> 30) / 6;
    return (th * h) >> 30;
  endfunction

  // Q1.15 cosine of k/Depth turns, evaluated at elaboration for a constant table.
  function automatic logic signed [15:0] cos_entry(input int k, input int Depth);
    logic [63:0] tq;
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] m;
    logic [1:0]  q;
    logic        neg;
    tq = ((64'(k) << 32) / Depth) & 64'hFFFF_FFFF;
    q = tq[31:30];
    r = tq & 64'h3FFF_FFFF;
    if (r <= (64'd1 << 29)) begin
      c = cos_q30(angle_q30(r));
      s = sin_q30(angle_q30(r));
    end else begin
      c = sin_q30(angle_q30(Q30_ONE - r));
      s = cos_q30(angle_q30(Q30_ONE - r));
    end
    case (q)
      2'd0: begin v = c; neg = 1'b0; end
      2'd1: begin v = s; neg = 1'b1; end
      2'd2: begin v = c; neg = 1'b1; end
      default: begin v = s; neg = 1'b0; end
    endcase
    m = (v + (64'd1 << 14)) >> 15;
    if (m > 64'd32767) m = 64'd32767;
    return neg ? -$signed(m[15:0]) : $signed(m[15:0]);
  endfunction

endpackage

>>> rtl/cdb_ram.sv
// ----------------------------------------------------------------------------
// cdb_ram
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
// ----------------------------------------------------------------------------
module cdb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cdb_divider.sv
// ----------------------------------------------------------------------------
// cdb_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdb_divider #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // Shift one numerator bit into the remainder and try a subtract.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[DW-1:0], quo_r[NW-1]};
      quo_nxt = {quo_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/cdb_front.sv
// ----------------------------------------------------------------------------
// cdb_front
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module cdb_front
  import cdb_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic        in_first_sample,
  input  logic [15:0] in_sample,
  input  logic [15:0] in_frequency_index,
  output logic        q_valid,
  input  logic        q_pop,
  output cdb_item_t   q_item
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cdb_item_t     slot_r [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push;

  assign in_stall = (cnt_r == (AW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = slot_r[rp_r];

  // Queue pointers wrap at the depth.
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (q_pop) rp_nxt = (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r].is_load <= (in_command == CMD_LOAD);
      slot_r[wp_r].first   <= in_first_sample;
      slot_r[wp_r].smp     <= in_sample;
      slot_r[wp_r].freq    <= in_frequency_index;
    end
  end

endmodule

>>> rtl/cdb_back.sv
// ----------------------------------------------------------------------------
// cdb_back
// Executes loads into the sample RAM and runs the bin accumulation.
// ----------------------------------------------------------------------------
module cdb_back
  import cdb_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         divisor,
  input  logic               q_valid,
  output logic               q_pop,
  input  cdb_item_t          q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_bin_index,
  output logic signed [23:0] out_bin_value,
  output logic               out_empty_window
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int TW = $clog2(COS_TABLE_DEPTH);
  localparam int DENW = 8 + CW;
  localparam int RDW = CW + 7;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_STEP = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_DRN  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  logic signed [15:0] cos_rom [COS_TABLE_DEPTH];
  for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
    assign cos_rom[g] = cos_entry(g, COS_TABLE_DEPTH);
  end

  state_t        st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r;
  logic [31:0]   phase_r;
  logic [31:0]   step_r;
  logic signed [47:0] acc_r;
  logic signed [31:0] prod_r;
  logic          prod_v_r, rd_v_r;
  logic signed [15:0] cos_r;
  logic [15:0]   freq_r;
  logic          neg_r;
  logic [RDW-1:0] half_r;
  logic [47:0]   tprod;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_rdata;
  logic [CW-1:0] wr_pos;

  logic          div_start, div_done;
  logic [63:0]   div_num;
  logic [DENW-1:0] div_den;
  logic [63:0]   div_quo;
  logic [7:0]    div_eff;
  logic [47:0]   mag;

  assign div_eff = (divisor == 8'd0) ? 8'd1 : divisor;
  assign mag = acc_r[47] ? 48'(-acc_r) : 48'(acc_r);

  // Table index is the phase scaled by the table depth, low 32 bits dropped.
  assign tprod = 48'(phase_r) * 48'(COS_TABLE_DEPTH);

  // Loads store at the current count, or at zero when the window restarts.
  assign wr_pos    = q_item.first ? '0 : count_r;
  assign ram_we    = (st_r == S_IDLE) && q_valid && q_item.is_load &&
                     (wr_pos < CW'(MAX_SAMPLES));
  assign ram_waddr = wr_pos[AW-1:0];

  cdb_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.smp),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Step division: round((f+1)*2^32 / (D*N)); later the mean division.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if ((st_r == S_IDLE) && q_valid && !q_item.is_load && (count_r != '0)) begin
      div_start = 1'b1;
      div_den   = DENW'(div_eff) * DENW'(count_r);
      div_num   = ({31'd0, 17'(q_item.freq) + 17'd1, 16'd0} << 16) + 64'(div_den >> 1);
    end else if (st_r == S_DRN && !prod_v_r && !rd_v_r) begin
      div_start = 1'b1;
      div_den   = DENW'({count_r, 7'd0});
      div_num   = 64'(mag) + 64'(half_r);
    end
  end

  cdb_divider #(.NW(64), .DW(DENW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign q_pop = (st_r == S_IDLE) && q_valid &&
                 (q_item.is_load || (count_r == '0) || div_start);

  // Sequencer.
  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.is_load) begin
            if (wr_pos < CW'(MAX_SAMPLES)) count_nxt = wr_pos + 1'b1;
            else count_nxt = wr_pos;
          end else if (count_r == '0) begin
            st_nxt = S_OUT;
          end else begin
            st_nxt = S_STEP;
          end
        end
      end
      S_STEP: if (div_done) st_nxt = S_ACC;
      S_ACC:  if (idx_r == count_r - 1'b1) st_nxt = S_DRN;
      S_DRN:  if (div_start) st_nxt = S_DIV;
      S_DIV:  if (div_done) st_nxt = S_FIN;
      S_FIN:  st_nxt = S_OUT;
      S_OUT:  if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      count_r  <= '0;
      prod_v_r <= 1'b0;
      rd_v_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      count_r  <= count_nxt;
      rd_v_r   <= (st_r == S_ACC);
      prod_v_r <= rd_v_r;
    end
    // Command capture.
    if (q_pop && !q_item.is_load) begin
      freq_r  <= q_item.freq;
      idx_r   <= '0;
      phase_r <= '0;
      acc_r   <= '0;
      half_r  <= RDW'({count_r, 6'd0});
    end
    if (st_r == S_STEP && div_done) step_r <= div_quo[31:0];
    // Address walk; the table value tracks the RAM read latency.
    if (st_r == S_ACC) begin
      idx_r   <= idx_r + 1'b1;
      phase_r <= phase_r + step_r;
      cos_r   <= cos_rom[tprod[32 +: TW]];
    end
    if (rd_v_r) prod_r <= $signed(ram_rdata) * cos_r;
    if (prod_v_r) acc_r <= acc_r + 48'(prod_r);
    if (st_r == S_DRN && div_start) neg_r <= acc_r[47];
    // Saturate and sign the rounded mean.
    if (st_r == S_DIV && div_done) begin
      if (neg_r) begin
        out_bin_value <= (div_quo >= 64'd8388608) ? $signed(24'h80_0000) :
                         -$signed(div_quo[23:0]);
      end else begin
        out_bin_value <= (div_quo >= 64'd8388607) ? 24'sd8388607 : $signed(div_quo[23:0]);
      end
    end
    if (st_r == S_IDLE && q_valid && !q_item.is_load && count_r == '0) begin
      out_bin_value <= '0;
    end
  end

  assign out_valid        = (st_r == S_OUT);
  assign out_bin_index    = freq_r;
  assign out_empty_window = (count_r == '0);

endmodule

>>> rtl/cosine_dft_bin_unit.sv
// ----------------------------------------------------------------------------
// cosine_dft_bin_unit
// Real part of a single-bin DFT over a loaded window of audio samples.
// ----------------------------------------------------------------------------
// A compute item uses the serial divider for the phase step, then walks the
// stored samples, reading one RAM entry and doing one multiply-accumulate per
// cycle, and then uses the serial divider again for the final mean. An empty
// window answers with a zero value and the empty flag set.
module cosine_dft_bin_unit
  import cdb_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic               in_first_sample,
  input  logic signed [15:0] in_sample,
  input  logic [15:0]        in_frequency_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_bin_index,
  output logic signed [23:0] out_bin_value,
  output logic               out_empty_window
);

  logic [7:0] divisor_r;
  logic       q_valid, q_pop;
  cdb_item_t  q_item;

  // Divisor register.
  always_ff @(posedge clk) begin
    if (!rst_n) divisor_r <= DIVISOR_RESET;
    else if (cfg_we) divisor_r <= cfg_wdata;
  end

  cdb_front #(.QDEPTH(2)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_first_sample    (in_first_sample),
    .in_sample          (in_sample),
    .in_frequency_index (in_frequency_index),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_item             (q_item)
  );

  cdb_back #(.MAX_SAMPLES(MAX_SAMPLES), .COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .divisor          (divisor_r),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bin_index    (out_bin_index),
    .out_bin_value    (out_bin_value),
    .out_empty_window (out_empty_window)
  );

endmodule
